@@ design/bdlt_pkg.sv @@
// Shared types and constants for the button debounce and lap timer block.
`default_nettype none
package bdlt_pkg;

    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned SUM_W    = 7;
    localparam int unsigned MIN_W    = 16;
    localparam int unsigned LAPS_W   = 8;
    localparam int unsigned LEVEL_W  = 11;
    localparam int unsigned ID_W     = 4;
    localparam int unsigned IDX5_W   = 5;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic [TIMER_W-1:0] SETTLE_RESET = 16'd50;
    localparam logic [TIMER_W-1:0] SEC_PER_MIN  = 16'd60;
    localparam logic [IDX5_W-1:0]  LAP_BUTTON   = 5'd5;

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic REG_SETTLE = 1'b0;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [TIMER_W-1:0] a;
        logic [TIMER_W-1:0] b;
    } t_alu_req;

    // co: carry out on add, borrow (a < b) on subtract
    typedef struct packed {
        logic [TIMER_W-1:0] res;
        logic               co;
    } t_alu_rsp;

    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    button;
        logic [LEVEL_W-1:0] pin_levels;
        logic [SEC_W-1:0]   lap_seconds;
        logic [MIN_W-1:0]   lap_minutes;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   button_id;
        logic              pressed;
        logic              report;
        logic [3:0]        leds;
        logic              lap_done;
        logic [LAPS_W-1:0] lap_count;
        logic [SEC_W-1:0]  total_seconds;
        logic [MIN_W-1:0]  total_minutes;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } t_led_map;

    // Buttons 0, 1, 5 and 6 drive LEDs 0..3 and are reported.
    function automatic t_led_map led_slot(input logic [IDX5_W-1:0] idx);
        t_led_map m;
        m = '0;
        case (idx)
            5'd0: begin m.hit = 1'b1; m.slot = 2'd0; end
            5'd1: begin m.hit = 1'b1; m.slot = 2'd1; end
            5'd5: begin m.hit = 1'b1; m.slot = 2'd2; end
            5'd6: begin m.hit = 1'b1; m.slot = 2'd3; end
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ design/button_debounce_lap_timer_unit.sv @@
// Top level: debouncer sequencer, event output register and lap arithmetic.
// Usage
//   Input channel (i_in_valid / o_in_stall) carries edge words (cmd 0) and tick
//   words (cmd 1). Output channel (o_out_valid / i_out_stall) carries one word
//   per debounced state change; 'last' marks the final word of one expiry.
//   settle_ticks is written over APB at byte address 0; the user must write
//   it only while the block is idle, which the block itself does not enforce.
// Sequencing
//   Edge word: taken directly in idle. Tick word with no expiry: accept, timer
//   add, limit compare, the add and compare both on the one shared 16-bit
//   adder. Expiring tick: after the compare, one scan step per button index up
//   to the last changed one (one when nothing changed), plus one emit step per
//   event; a lap press adds a seconds add, a minutes add, a compare and a
//   minute carry per minus-60 step (at most two), a closing compare and the
//   lap increment. o_in_stall is high whenever the sequencer is busy.
// Stalls and reset
//   Each event sits in an output register; a stalled receiver holds the word
//   and the sequencer waits in its emit step. Reset clears pending, debounced
//   state, LEDs, totals, lap count, timer and settle_ticks (to 50).
`default_nettype none
module button_debounce_lap_timer_unit #(
    parameter int unsigned BUTTON_COUNT = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bdlt_pkg::t_in_word            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bdlt_pkg::t_out_word           o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlt_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdlt_pkg::DATA_W-1:0]   pwdata,
    output logic [bdlt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned BW = BUTTON_COUNT;
    localparam int unsigned IW = $clog2(BUTTON_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_CMP,
        S_SCAN,
        S_SEC,
        S_MIN,
        S_MOD,
        S_CARRY,
        S_LAPS,
        S_EMIT
    } t_state;

    t_state                           r_state;
    bdlt_pkg::t_in_word               r_in;
    logic [BW-1:0]                    r_pending;
    logic [BW-1:0]                    r_debounced;
    logic [BW-1:0]                    r_chg;
    logic                             r_running;
    logic [bdlt_pkg::TIMER_W-1:0]     r_timer;
    logic [3:0]                       r_leds;
    logic [bdlt_pkg::SUM_W-1:0]       r_sec;
    logic [bdlt_pkg::MIN_W-1:0]       r_min;
    logic [bdlt_pkg::LAPS_W-1:0]      r_laps;
    logic [IW-1:0]                    r_idx;
    logic                             r_now;
    logic                             r_lap;
    logic                             r_out_valid;
    bdlt_pkg::t_out_word              r_out;

    logic [bdlt_pkg::TIMER_W-1:0]     w_settle;
    logic [bdlt_pkg::TIMER_W-1:0]     w_limit;
    bdlt_pkg::t_alu_req               w_alu_req;
    bdlt_pkg::t_alu_rsp               w_alu_rsp;
    logic                             w_accept;
    logic [BW-1:0]                    w_edge_bit;
    logic                             w_edge_ok;
    logic [BW-1:0]                    w_pressed;
    logic [BW-1:0]                    w_cur_bit;
    logic                             w_last;
    logic                             w_load;
    logic                             w_expire;
    bdlt_pkg::t_led_map               w_led;

    bdlt_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_settle (w_settle)
    );

    bdlt_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_limit    = (w_settle == '0) ? 16'd1 : w_settle;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_edge_bit = BW'(1) << i_in.button;
    assign w_edge_ok  = ({2'b00, i_in.button} < 6'(BUTTON_COUNT))
                        && ((r_pending & w_edge_bit) == '0);

    // pins beyond the level field read as low, i.e. pressed
    assign w_pressed = ~BW'(r_in.pin_levels);
    assign w_cur_bit = BW'(1) << r_idx;
    assign w_last    = (r_chg == w_cur_bit);
    assign w_expire  = (r_state == S_CMP) && !w_alu_rsp.co;
    assign w_load    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_led     = bdlt_pkg::led_slot(bdlt_pkg::IDX5_W'(r_idx));

    always_comb begin
        w_alu_req.op = bdlt_pkg::ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        case (r_state)
            S_TICK: begin
                w_alu_req.a = r_timer;
                w_alu_req.b = 16'd1;
            end
            S_CMP: begin
                w_alu_req.op = bdlt_pkg::ALU_SUB;
                w_alu_req.a  = r_timer;
                w_alu_req.b  = w_limit;
            end
            S_SEC: begin
                w_alu_req.a = 16'(r_sec);
                w_alu_req.b = 16'(r_in.lap_seconds);
            end
            S_MIN: begin
                w_alu_req.a = r_min;
                w_alu_req.b = r_in.lap_minutes;
            end
            S_MOD: begin
                w_alu_req.op = bdlt_pkg::ALU_SUB;
                w_alu_req.a  = 16'(r_sec);
                w_alu_req.b  = bdlt_pkg::SEC_PER_MIN;
            end
            S_CARRY: begin
                w_alu_req.a = r_min;
                w_alu_req.b = 16'd1;
            end
            S_LAPS: begin
                w_alu_req.a = 16'(r_laps);
                w_alu_req.b = 16'd1;
            end
            default: begin
                w_alu_req.op = bdlt_pkg::ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= '0;
            r_debounced <= '0;
            r_chg       <= '0;
            r_running   <= 1'b0;
            r_timer     <= '0;
            r_leds      <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_laps      <= '0;
            r_idx       <= '0;
            r_now       <= 1'b0;
            r_lap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in <= i_in;
                        if (i_in.cmd == bdlt_pkg::CMD_EDGE) begin
                            if (w_edge_ok) begin
                                r_pending <= r_pending | w_edge_bit;
                                r_timer   <= '0;
                                r_running <= 1'b1;
                            end
                        end else if (r_running) begin
                            r_state <= S_TICK;
                        end
                    end
                end
                S_TICK: begin
                    r_timer <= w_alu_rsp.res;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_expire) begin
                        r_running <= 1'b0;
                        r_pending <= '0;
                        r_chg     <= r_pending & (w_pressed ^ r_debounced);
                        r_idx     <= '0;
                        r_state   <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_chg == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_chg[r_idx]) begin
                        r_debounced[r_idx] <= ~r_debounced[r_idx];
                        r_now              <= ~r_debounced[r_idx];
                        if (w_led.hit) begin
                            r_leds[w_led.slot] <= ~r_debounced[r_idx];
                        end
                        if ((bdlt_pkg::IDX5_W'(r_idx) == bdlt_pkg::LAP_BUTTON)
                            && !r_debounced[r_idx]) begin
                            r_lap   <= 1'b1;
                            r_state <= S_SEC;
                        end else begin
                            r_lap   <= 1'b0;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_SEC: begin
                    r_sec   <= bdlt_pkg::SUM_W'(w_alu_rsp.res);
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    r_min   <= w_alu_rsp.res;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // subtract 60 until the seconds are below a minute
                    if (!w_alu_rsp.co) begin
                        r_sec   <= bdlt_pkg::SUM_W'(w_alu_rsp.res);
                        r_state <= S_CARRY;
                    end else begin
                        r_state <= S_LAPS;
                    end
                end
                S_CARRY: begin
                    r_min   <= w_alu_rsp.res;
                    r_state <= S_MOD;
                end
                S_LAPS: begin
                    r_laps  <= bdlt_pkg::LAPS_W'(w_alu_rsp.res);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out.button_id     <= bdlt_pkg::ID_W'(r_idx);
                        r_out.pressed       <= r_now;
                        r_out.report        <= w_led.hit;
                        r_out.leds          <= r_leds;
                        r_out.lap_done      <= r_lap;
                        r_out.lap_count     <= r_laps;
                        r_out.total_seconds <= bdlt_pkg::SEC_W'(r_sec);
                        r_out.total_minutes <= r_min;
                        r_out.last          <= w_last;
                        r_chg[r_idx]        <= 1'b0;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_expire_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_expire |=> (!r_running && (r_pending == '0)))
        else $error("timer still running or buttons pending after expiry");

    a_idle_no_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_chg == '0))
        else $error("unsent changes left when sequencer went idle");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> ((r_chg == '0) && o_out_valid && o_out.last))
        else $error("last word sent with changes still outstanding");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (16'(r_sec) < bdlt_pkg::SEC_PER_MIN))
        else $error("seconds total not reduced below one minute");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |=> ((r_state == S_CMP) && o_in_stall))
        else $error("tick sequence left the compare step out");

endmodule
`default_nettype wire

@@ design/bdlt_alu.sv @@
// Shared 16-bit add/subtract unit used by the sequencer for its timer, limit, totals and lap-count arithmetic.
`default_nettype none
module bdlt_alu (
    input  bdlt_pkg::t_alu_req i_req,
    output bdlt_pkg::t_alu_rsp o_rsp
);

    logic [bdlt_pkg::TIMER_W:0] w_sum;

    always_comb begin
        case (i_req.op)
            bdlt_pkg::ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            bdlt_pkg::ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:           w_sum = '0;
        endcase
    end

    assign o_rsp.res = w_sum[bdlt_pkg::TIMER_W-1:0];
    assign o_rsp.co  = w_sum[bdlt_pkg::TIMER_W];

endmodule
`default_nettype wire

@@ design/bdlt_cfg.sv @@
// APB register file holding the settle time.
`default_nettype none
module bdlt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlt_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdlt_pkg::DATA_W-1:0]   pwdata,
    output logic [bdlt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [bdlt_pkg::TIMER_W-1:0]  o_settle
);

    logic [bdlt_pkg::TIMER_W-1:0] r_settle;
    logic                         w_sel_settle;

    assign w_sel_settle = (paddr[2] == bdlt_pkg::REG_SETTLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= bdlt_pkg::SETTLE_RESET;
        end else if (psel && penable && pwrite && w_sel_settle) begin
            r_settle <= pwdata[bdlt_pkg::TIMER_W-1:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = w_sel_settle ?
                      {{(bdlt_pkg::DATA_W-bdlt_pkg::TIMER_W){1'b0}}, r_settle} : '0;
    assign o_settle = r_settle;

endmodule
`default_nettype wire
